FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also runs through reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/rfrc_pkg.sv
// types and codes for the relay frame receive control block
package rfrc_pkg;

  localparam int CHAN_W   = 3;
  localparam int SEQ_W    = 16;
  localparam int LEN_W    = 12;
  localparam int STA_W    = 4;
  localparam int OFF_W    = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 1;
  localparam logic [OFF_W-1:0] BUF_MAX = 13'd4096;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_STATION      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REASSEMBLY_LIMIT = 1'd1;

  typedef enum logic [2:0] {
    ACT_DUP_DROP     = 3'd0,
    ACT_FOREIGN_DROP = 3'd1,
    ACT_RELAY        = 3'd2,
    ACT_STORE_FRAG   = 3'd3,
    ACT_DELIVER_REASM = 3'd4,
    ACT_DELIVER_OVFL = 3'd5,
    ACT_DELIVER_SINGLE = 3'd6
  } action_t;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [SEQ_W-1:0]  sequence_req;
    logic              relay_flag;
    logic              fragment_flag;
    logic              last_flag;
    logic [LEN_W-1:0]  payload_length;
    logic              target_found;
    logic [STA_W-1:0]  target_station;
  } hdr_t;

  // first member lands in the top bits, so action sits at bit 0
  typedef struct packed {
    logic             lost_partial;
    logic [OFF_W-1:0] deliver_length;
    logic [OFF_W-1:0] write_offset;
    logic             relay_flag_out;
    logic [1:0]       relay_direction;
    action_t          action;
  } result_t;

  typedef struct packed {
    logic [SEQ_W-1:0] last_sequence;
    logic             assembling;
    logic [OFF_W-1:0] fill_offset;
  } chan_state_t;

endpackage

FILE: rtl/rfrc_chan_state.sv
// per-channel sequence and reassembly state, one read and one write port
module rfrc_chan_state #(
  parameter int CHANNELS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [rfrc_pkg::CHAN_W-1:0] channel,
  input  logic                     we,
  input  rfrc_pkg::chan_state_t    wr_state,
  output rfrc_pkg::chan_state_t    rd_state
);
  import rfrc_pkg::*;

  // the channel field only reaches 2**CHAN_W entries
  localparam int DEPTH = (CHANNELS < (1 << CHAN_W)) ? CHANNELS : (1 << CHAN_W);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  chan_state_t state [DEPTH];
  logic [IDX_W-1:0] idx;

  assign idx      = IDX_W'(channel);
  assign rd_state = state[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        state[i] <= '0;
      end
    end else if (we) begin
      state[idx] <= wr_state;
    end
  end

endmodule

FILE: rtl/rfrc_decide.sv
// action decision and next channel state for one frame header
module rfrc_decide #(
  parameter int CHANNELS = 8,
  parameter int STATIONS = 16
) (
  input  rfrc_pkg::hdr_t                 hdr,
  input  rfrc_pkg::chan_state_t          st,
  input  logic [rfrc_pkg::STA_W-1:0]     own_station,
  input  logic [rfrc_pkg::CFG_W-1:0]     reassembly_limit,
  output rfrc_pkg::result_t              res,
  output rfrc_pkg::chan_state_t          st_next,
  output logic                           st_we
);
  import rfrc_pkg::*;

  logic             chan_ok;
  logic             is_new;
  logic             tgt_ok;
  logic [OFF_W-1:0] limit;
  logic [OFF_W-1:0] fill_eff;
  logic [OFF_W:0]   sum;
  logic             overflow;
  logic [STA_W:0]   tgt_inc;
  logic [STA_W:0]   own_inc;

  assign chan_ok  = int'(hdr.channel) < CHANNELS;
  assign is_new   = chan_ok && (st.last_sequence != hdr.sequence_req);
  assign tgt_ok   = hdr.target_found && (int'(hdr.target_station) < STATIONS);
  assign limit    = (reassembly_limit > BUF_MAX) ? BUF_MAX : reassembly_limit;
  // a channel not assembling starts from offset zero
  assign fill_eff = st.assembling ? st.fill_offset : '0;
  assign sum      = {1'b0, fill_eff} + (OFF_W + 1)'(hdr.payload_length);
  assign overflow = sum > {1'b0, limit};
  assign tgt_inc  = {1'b0, hdr.target_station} + 1'b1;
  assign own_inc  = {1'b0, own_station} + 1'b1;

  assign st_we = is_new;

  always_comb begin
    res     = '0;
    res.action = ACT_DUP_DROP;
    st_next = st;
    st_next.last_sequence = hdr.sequence_req;
    if (is_new) begin
      if (hdr.relay_flag) begin
        if (!tgt_ok) begin
          res.action = ACT_FOREIGN_DROP;
        end else begin
          res.action = ACT_RELAY;
          res.relay_flag_out = !((tgt_inc == {1'b0, own_station}) ||
                                 ({1'b0, hdr.target_station} == own_inc));
          if (hdr.target_station > own_station) begin
            res.relay_direction = DIR_UP;
          end else if (hdr.target_station < own_station) begin
            res.relay_direction = DIR_DOWN;
          end else begin
            res.relay_direction = DIR_NONE;
          end
        end
      end else if (hdr.fragment_flag) begin
        if (overflow) begin
          res.action         = ACT_DELIVER_OVFL;
          res.deliver_length = limit;
          st_next.assembling  = 1'b0;
          st_next.fill_offset = '0;
        end else if (hdr.last_flag) begin
          res.action         = ACT_DELIVER_REASM;
          res.write_offset   = fill_eff;
          res.deliver_length = sum[OFF_W-1:0];
          st_next.assembling  = 1'b0;
          st_next.fill_offset = '0;
        end else begin
          res.action         = ACT_STORE_FRAG;
          res.write_offset   = fill_eff;
          st_next.assembling  = 1'b1;
          st_next.fill_offset = sum[OFF_W-1:0];
        end
      end else begin
        res.action          = ACT_DELIVER_SINGLE;
        res.deliver_length  = OFF_W'(hdr.payload_length);
        res.lost_partial    = st.assembling;
        st_next.assembling  = 1'b0;
        st_next.fill_offset = '0;
      end
    end
  end

endmodule

FILE: rtl/relay_frame_receive_control.sv
// top level of the relay frame receive control block
//
// takes one received relay frame header per request on the s_ side and
// gives exactly one action request per header on the m_ side
// s_tdata holds channel, sequence, payload length, target found and target
// station; s_tuser holds the relay and fragment flags; s_tlast is the
// last-fragment flag
// one header register feeds the decision logic, whose result and the
// updated channel state are written at the same edge into the output
// register and the per-channel state flops
// each header goes through the header register, then the output register
// throughput: one header per cycle while the m_ side is not stalled, as
// the per-channel state flops are read and rewritten with each result
// a stalled m_ side holds its result; the header register still takes one
// more request, then s_tready drops until the output is taken
// reset clears all channel state (sequence, assembling, offset) at once,
// sets own_station to 0 and reassembly_limit to 4096, and empties both
// registers; the user writes configuration via cfg_we/cfg_addr/cfg_data
// only while the block is idle; the block itself does not enforce this
module relay_frame_receive_control #(
  parameter int CHANNELS = 8,
  parameter int STATIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [rfrc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [rfrc_pkg::CFG_W-1:0]     cfg_data,
  // header requests
  input  logic        s_tvalid,
  output logic        s_tready,
  // channel, sequence_req, payload_length, target_found, target_station
  input  logic [39:0] s_tdata,
  // relay_flag, fragment_flag
  input  logic [1:0]  s_tuser,
  input  logic        s_tlast,
  // action requests
  output logic        m_tvalid,
  input  logic        m_tready,
  // action, relay_direction, relay_flag_out, write_offset, deliver_length,
  // lost_partial
  output logic [39:0] m_tdata
);
  import rfrc_pkg::*;

  logic [STA_W-1:0] own_station;
  logic [CFG_W-1:0] reassembly_limit;

  hdr_t        hdr_in;
  hdr_t        hdr_q;
  logic        hdr_valid;
  logic        advance;
  logic        s_take;
  result_t     res;
  result_t     res_q;
  chan_state_t st_rd;
  chan_state_t st_next;
  logic        st_we;

  // unpack the stream request into header fields
  always_comb begin
    hdr_in.channel        = s_tdata[2:0];
    hdr_in.sequence_req   = s_tdata[18:3];
    hdr_in.payload_length = s_tdata[30:19];
    hdr_in.target_found   = s_tdata[31];
    hdr_in.target_station = s_tdata[35:32];
    hdr_in.relay_flag     = s_tuser[0];
    hdr_in.fragment_flag  = s_tuser[1];
    hdr_in.last_flag      = s_tlast;
  end

  // output register frees up when empty or taken this cycle
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !hdr_valid || advance;
  assign s_take   = s_tvalid && s_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_station      <= '0;
      reassembly_limit <= BUF_MAX;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_OWN_STATION) begin
        own_station <= cfg_data[STA_W-1:0];
      end else if (cfg_addr == CFG_REASSEMBLY_LIMIT) begin
        reassembly_limit <= cfg_data;
      end
    end
  end

  // header register
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_valid <= 1'b0;
    end else if (s_take) begin
      hdr_valid <= 1'b1;
    end else if (advance) begin
      hdr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      hdr_q <= hdr_in;
    end
  end

  rfrc_chan_state #(
    .CHANNELS(CHANNELS)
  ) u_state (
    .clk      (clk),
    .rst      (rst),
    .channel  (hdr_q.channel),
    .we       (hdr_valid && advance && st_we),
    .wr_state (st_next),
    .rd_state (st_rd)
  );

  rfrc_decide #(
    .CHANNELS(CHANNELS),
    .STATIONS(STATIONS)
  ) u_decide (
    .hdr              (hdr_q),
    .st               (st_rd),
    .own_station      (own_station),
    .reassembly_limit (reassembly_limit),
    .res              (res),
    .st_next          (st_next),
    .st_we            (st_we)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= hdr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hdr_valid) begin
      res_q <= res;
    end
  end

  assign m_tdata = {7'b0, res_q};

endmodule

FILE: rtl/rfrc_checker.sv
// port-level checks for the relay frame receive control block
`include "assert_macros.svh"

module rfrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);
  import rfrc_pkg::*;

  logic             s_take;
  logic             non_relay;
  logic [2:0]       relay_bits;
  logic [OFF_W-1:0] dlen;

  assign s_take     = s_tvalid && s_tready;
  assign non_relay  = m_tvalid && (m_tdata[2:0] != ACT_RELAY);
  // relay_direction and relay_flag_out
  assign relay_bits = m_tdata[5:3];
  assign dlen       = m_tdata[31:19];

  `ASSERT_CLK_ALWAYS(a_reset_empties, rst |=> !m_tvalid, "output valid after reset")

  `ASSERT_CLK(a_valid_holds, (m_tvalid && !m_tready) |=> m_tvalid, "stalled result dropped")

  `ASSERT_CLK(a_dir_only_relay, non_relay |-> (relay_bits == 3'd0), "stray relay fields")

  `ASSERT_CLK(a_deliver_bound, m_tvalid |-> (dlen <= BUF_MAX), "delivery beyond buffer size")

  `ASSERT_CLK(a_one_result_per_req, (!m_tvalid && !$past(s_take)) |=> !m_tvalid, "unrequested result")

endmodule

bind relay_frame_receive_control rfrc_checker u_rfrc_checker (.*);
